// ===== rtl/ssbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_pkg
// Types and constants shared by the sorted store and binary search core.
// ----------------------------------------------------------------------------
package ssbs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } ssbs_op_e;

  typedef struct packed {
    ssbs_op_e                  operation;
    logic signed [ValueW-1:0]  value;
  } ssbs_in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } ssbs_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                      load;
    logic                      search;
    logic signed [ValueW-1:0]  value;
  } ssbs_cell_ctrl_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_PROBE = 1'b1
  } ssbs_state_e;

endpackage : ssbs_pkg
`default_nettype wire

// ===== rtl/ssbs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_cell
// One slot of the sorted row: holds an entry, shifts toward the tail on an
// insert, and registers its compare flags against a search key.
// ----------------------------------------------------------------------------
module ssbs_cell
  import ssbs_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ssbs_cell_ctrl_t          ctrl_i,
  input  wire                      valid_i,
  input  wire                      tail_i,
  input  wire signed [ValueW-1:0]  left_entry_i,
  input  wire                      left_gt_i,
  output logic signed [ValueW-1:0] entry_o,
  output logic                     gt_o,
  output logic                     key_greater_o,
  output logic                     key_less_o
);

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     key_greater_q, key_less_q;

  // entry is above the broadcast value
  assign gt_o = valid_i && (entry_q > ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || tail_i) begin
        entry_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_greater_q <= 1'b0;
      key_less_q    <= 1'b0;
    end else if (ctrl_i.search) begin
      key_greater_q <= ctrl_i.value > entry_q;
      key_less_q    <= ctrl_i.value < entry_q;
    end
  end

  assign entry_o       = entry_q;
  assign key_greater_o = key_greater_q;
  assign key_less_o    = key_less_q;

endmodule : ssbs_cell
`default_nettype wire

// ===== rtl/sorted_store_binary_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_store_binary_search_core
// Sorted row of DEPTH signed entries with insert and binary search.
// ----------------------------------------------------------------------------
// A load beat does not stall the input: every cell compares its entry with
// the value at once and the row shifts by one slot to open the sorted
// position, so the next beat can follow right away; a load into a full
// store is dropped. A search beat registers each cell's compare flags
// against the key on the accepting edge, then walks the classic
// (first+last)/2 midpoint sequence over those flags, one probe a cycle,
// a hit probe holding while an earlier result waits stalled in the output
// register. A hit writes the result register in its probe cycle and a
// miss writes it once the range is empty, either only once the output
// register is free; until then the input stays stalled. A finished result
// waits in the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module sorted_store_binary_search_core
  import ssbs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  ssbs_in_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output ssbs_out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ssbs_state_e     state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   lo_q, lo_d;
  logic [CW-1:0]   hi1_q, hi1_d;       // upper bound plus one
  logic            out_valid_q, out_valid_d;
  ssbs_out_t       out_q, out_d;

  logic            in_fire;
  logic            full;
  ssbs_cell_ctrl_t cell_ctrl;

  logic signed [ValueW-1:0] entry [DEPTH];
  logic [DEPTH-1:0]         gt_vec;
  logic [DEPTH-1:0]         greater_vec;
  logic [DEPTH-1:0]         less_vec;

  logic [CW:0]     mid_sum;
  logic [AW-1:0]   mid;
  logic [AW+PosW-1:0] mid_ext;
  logic            range_open;
  logic            out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(DEPTH));

  assign cell_ctrl.load   = in_fire && (in_data_i.operation == OP_LOAD) && !full;
  assign cell_ctrl.search = in_fire && (in_data_i.operation == OP_SEARCH);
  assign cell_ctrl.value  = in_data_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] left_entry;
    logic                     left_gt;
    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_gt    = gt_vec[i-1];
    end
    ssbs_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .valid_i       (CW'(i) < count_q),
      .tail_i        (CW'(i) == count_q),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .entry_o       (entry[i]),
      .gt_o          (gt_vec[i]),
      .key_greater_o (greater_vec[i]),
      .key_less_o    (less_vec[i])
    );
  end

  // midpoint of [lo, hi1-1]; only used while lo < hi1
  assign mid_sum    = (CW+1)'(lo_q) + (CW+1)'(hi1_q) - (CW+1)'(1);
  assign mid        = mid_sum[AW:1];
  assign mid_ext    = (AW+PosW)'(mid);
  assign range_open = lo_q < hi1_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi1_d       = hi1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cell_ctrl.load) begin
          count_d = count_q + CW'(1);
        end
        if (cell_ctrl.search) begin
          lo_d    = '0;
          hi1_d   = count_q;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!range_open) begin
          if (out_free) begin
            out_valid_d    = 1'b1;
            out_d.found    = 1'b0;
            out_d.position = '0;
            state_d        = ST_IDLE;
          end
        end else if (greater_vec[mid]) begin
          lo_d = CW'(mid) + CW'(1);
        end else if (less_vec[mid]) begin
          hi1_d = CW'(mid);
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.found    = 1'b1;
          out_d.position = mid_ext[PosW-1:0];
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi1_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      lo_q        <= lo_d;
      hi1_q       <= hi1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : sorted_store_binary_search_core
`default_nettype wire

// ===== rtl/ssbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssbs_checker
// Port-level checks for the sorted store core, bound to the top level.
// ----------------------------------------------------------------------------
module ssbs_checker
  import ssbs_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input ssbs_in_t  in_data_i,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input ssbs_out_t out_data_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a miss always reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.position == '0)
    else $error("miss with nonzero position");

  // an accepted search beat is followed by a stalled input
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.operation == OP_SEARCH |=> in_stall_o)
    else $error("input taken during search");

  // the input is not stalled in the cycle after a load beat
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.operation == OP_LOAD |=> !in_stall_o)
    else $error("input stalled after load");

endmodule : ssbs_checker

bind sorted_store_binary_search_core ssbs_checker u_ssbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
